/* rtl/core/ir_sensor_scan_framer_macros.svh */
// ----------------------------------------------------------------------------
// IR sensor scan framer assertion macros
// Shorthand for clocked implication checks, gated by reset.
// ----------------------------------------------------------------------------
`ifndef IR_SENSOR_SCAN_FRAMER_MACROS_SVH
`define IR_SENSOR_SCAN_FRAMER_MACROS_SVH

// Same-cycle implication.
`define ISSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ISSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/issf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR sensor scan framer package
// Request payload types, sequencer states and frame constants.
// ----------------------------------------------------------------------------
package issf_pkg;

  typedef struct packed {
    logic [15:0] sample;
    logic        start_ok;
    logic        conv_ok;
  } in_item_t;

  typedef struct packed {
    logic [7:0] emitter_mask;
    logic [2:0] scanned_channel;
    logic [7:0] frame_byte;
    logic       byte_valid;
    logic       frame_last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STATUS,
    ST_FRAME
  } issf_state_t;

  localparam logic [7:0]  SYNC_BYTE0   = 8'hAA;
  localparam logic [7:0]  SYNC_BYTE1   = 8'h55;
  localparam logic [15:0] TIMEOUT_MARK = 16'hFFFF;
  localparam int          HDR_BYTES    = 4;

endpackage : issf_pkg
`default_nettype wire

/* rtl/core/issf_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR sensor scan framer stream interface
// Valid/ready channel carrying one request payload.
// ----------------------------------------------------------------------------
interface issf_stream_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface : issf_stream_if
`default_nettype wire

/* rtl/core/ir_sensor_scan_framer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR sensor scan framer
// Stores one conversion per tick in a small sample RAM, rotates the emitter
// drive and, after the last channel, streams a checksummed frame byte-wise.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                   Handshake
// in_if     in   sample, start_ok, conv_ok                 valid/ready
// out_if    out  emitter_mask, scanned_channel,            valid/ready
//                frame_byte, byte_valid, frame_last
//
// A tick is an accept followed by a status result; the tick that samples the
// last channel then streams a frame of 2*CHANNELS+5 bytes, paced by the
// single read port of the sample RAM.
// Reset clears pointer, row counter and per-entry valid bits at once.
// Output stalls hold the sequencer; input is taken only between ticks.
// ----------------------------------------------------------------------------
`include "ir_sensor_scan_framer_macros.svh"

module ir_sensor_scan_framer
  import issf_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  issf_stream_if.sink    in_if,
  issf_stream_if.source  out_if
);

  localparam int FRAME_LEN = HDR_BYTES + 2 * CHANNELS + 1;
  localparam int CW        = $clog2(CHANNELS);
  localparam int BW        = $clog2(FRAME_LEN + 1);

  issf_state_t     state_r, state_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic [15:0]     row_r;
  logic            frame_r;
  logic [7:0]      mask_r;
  logic [2:0]      chan_r;
  logic [BW-1:0]   byte_idx_r;
  logic [7:0]      sum_r;
  logic            out_valid_r;
  out_item_t       out_pay_r, pay_nxt;

  logic [15:0]     mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  logic [15:0]     q_r;
  logic            qv_r;
  logic [15:0]     samp;

  logic            in_acc;
  logic            load_en;
  logic            in_ready;
  logic            emit;
  logic            last_byte;
  logic [BW-1:0]   nb, noff;
  logic [CW-1:0]   rd_addr;

  assign in_acc    = in_if.valid && in_ready;
  assign load_en   = !out_valid_r || out_if.ready;
  assign last_byte = (byte_idx_r == BW'(FRAME_LEN - 1));
  assign ptr_nxt   = (ptr_r == CW'(CHANNELS - 1)) ? '0 : ptr_r + CW'(1);
  assign samp      = qv_r ? q_r : 16'h0000;

  // Address the sample needed by the byte after the current one.
  assign nb   = byte_idx_r + BW'(1);
  assign noff = nb - BW'(HDR_BYTES);
  assign rd_addr = (state_r == ST_FRAME && nb >= BW'(HDR_BYTES) &&
                    nb <= BW'(FRAME_LEN - 2)) ? CW'(noff >> 1) : '0;

  assign in_if.ready    = in_ready;
  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_pay_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_STATUS;
      end
      ST_STATUS: begin
        if (load_en) state_nxt = frame_r ? ST_FRAME : ST_IDLE;
      end
      ST_FRAME: begin
        if (load_en && last_byte) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    emit     = 1'b0;
    pay_nxt.emitter_mask    = mask_r;
    pay_nxt.scanned_channel = chan_r;
    pay_nxt.frame_byte      = 8'h00;
    pay_nxt.byte_valid      = 1'b0;
    pay_nxt.frame_last      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // hold off requests while reset is applied
        in_ready = rst_n;
      end
      ST_STATUS: begin
        emit = 1'b1;
      end
      ST_FRAME: begin
        emit = 1'b1;
        pay_nxt.byte_valid = 1'b1;
        pay_nxt.frame_last = last_byte;
        if (last_byte) begin
          pay_nxt.frame_byte = sum_r;
        end else if (byte_idx_r == BW'(0)) begin
          pay_nxt.frame_byte = SYNC_BYTE0;
        end else if (byte_idx_r == BW'(1)) begin
          pay_nxt.frame_byte = SYNC_BYTE1;
        end else if (byte_idx_r == BW'(2)) begin
          pay_nxt.frame_byte = row_r[7:0];
        end else if (byte_idx_r == BW'(3)) begin
          pay_nxt.frame_byte = row_r[15:8];
        end else begin
          pay_nxt.frame_byte = byte_idx_r[0] ? samp[15:8] : samp[7:0];
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Sample RAM: write on accepted request with start_ok, registered read when advancing
  always_ff @(posedge clk) begin
    if (in_acc && in_if.payload.start_ok) begin
      mem[ptr_r] <= in_if.payload.conv_ok ? in_if.payload.sample : TIMEOUT_MARK;
    end
    if (load_en) begin
      q_r  <= mem[rd_addr];
      qv_r <= vld_r[rd_addr];
    end
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      row_r       <= 16'h0000;
      frame_r     <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      byte_idx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        ptr_r   <= ptr_nxt;
        frame_r <= (ptr_r == CW'(CHANNELS - 1));
        if (in_if.payload.start_ok) vld_r[ptr_r] <= 1'b1;
        if (ptr_r == CW'(CHANNELS - 1)) row_r <= row_r + 16'd1;
      end
      if (emit && load_en) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_STATUS) begin
        byte_idx_r <= '0;
      end else if (state_r == ST_FRAME && load_en) begin
        byte_idx_r <= byte_idx_r + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mask_r <= 8'd1 << ptr_nxt;
      chan_r <= 3'(32'(ptr_r));
    end
    if (emit && load_en) begin
      out_pay_r <= pay_nxt;
    end
    // Checksum covers row number and samples, not sync bytes or itself.
    if (state_r == ST_STATUS) begin
      sum_r <= 8'h00;
    end else if (state_r == ST_FRAME && load_en && !last_byte &&
                 byte_idx_r >= BW'(2)) begin
      sum_r <= sum_r + pay_nxt.frame_byte;
    end
  end

  `ISSF_ASSERT_NEXT(a_accept_to_status, in_acc, state_r == ST_STATUS,
                    "accepted request did not start a status result")
  `ISSF_ASSERT_NEXT(a_ptr_advance, in_acc, ptr_r != $past(ptr_r),
                    "channel pointer did not advance")
  `ISSF_ASSERT_NEXT(a_last_ends_frame, emit && load_en && pay_nxt.frame_last,
                    state_r == ST_IDLE, "frame did not end after checksum byte")
  `ISSF_ASSERT_NOW(a_mask_onehot, out_valid_r, $onehot0(out_pay_r.emitter_mask),
                   "emitter mask drives more than one channel")

endmodule : ir_sensor_scan_framer
`default_nettype wire
